// File: hw/rtl/scmap_pkg.sv
// Shared types and constants for the scalar colormap block.
// No dependencies; imported by every module of the block.
`default_nettype none

package scmap_pkg;

   localparam int SAMPLE_W = 16;   // signed Q4.12 sample
   localparam int CH_W     = 12;   // unsigned Q0.12 channel
   localparam int UNIT_W   = 13;   // clamped sample, 0..4096
   localparam int W_W      = 20;   // v' scaled by 35*4096

   localparam logic [UNIT_W-1:0] ONE_Q12  = 13'd4096;
   localparam logic [CH_W-1:0]   CH_MAX   = 12'hFFF;
   localparam logic [W_W-1:0]    MAP_GAIN = 20'd154;      // 4.4 * 35
   localparam logic [W_W-1:0]    MAP_OFFS = 20'd114688;   // 0.8 * 35 * 4096

   localparam logic [2:0] NBANDS = 3'd7;

   // (t + 35) / 70 as a multiply by ceil(2^25 / 70); exact while t + 35 stays
   // below 2^25 / 68 (about 493000), well above the largest positive t
   localparam int            RECIP_SHIFT = 25;
   localparam logic [18:0]   RECIP       = 19'd479350;
   localparam logic [18:0]   ROUND_BIAS  = 19'd35;

   typedef enum logic [1:0] {
      MODE_GREY      = 2'd0,
      MODE_RAINBOW   = 2'd1,
      MODE_RED_WHITE = 2'd2,
      MODE_BANDS     = 2'd3
   } mode_type;

   // Hump coefficients, already scaled by 35*4096
   typedef struct packed {
      logic [W_W-1:0] c_scaled;
      logic [W_W-1:0] a_scaled;
      logic [W_W-1:0] b_scaled;
   } hump_coef_type;

   localparam hump_coef_type RED_COEF   = '{20'd430080, 20'd573440, 20'd716800};
   localparam hump_coef_type GREEN_COEF = '{20'd573440, 20'd286720, 20'd573440};
   localparam hump_coef_type BLUE_COEF  = '{20'd430080, 20'd143360, 20'd286720};

   // Result of the first stage: scaled map position and the grey level
   typedef struct packed {
      logic [W_W-1:0]  w;
      logic [CH_W-1:0] grey;
   } map_type;

   // Band position: 4.4 * 35 * 4096 / 7 per band plus the offset
   function automatic logic [W_W-1:0] band_w(input logic [2:0] band);
      logic [W_W-1:0] res;
      case (band)
         3'd0:    res = 20'd114688;
         3'd1:    res = 20'd204800;
         3'd2:    res = 20'd294912;
         3'd3:    res = 20'd385024;
         3'd4:    res = 20'd475136;
         3'd5:    res = 20'd565248;
         3'd6:    res = 20'd655360;
         default: res = 20'd745472;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/scalar_colormap.sv
// Top level of the scalar colormap: mode register, three-register pipeline.
// Depends on scmap_pkg, scmap_warp and scmap_hump.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   req     | req_valid, req_stall, req_sample_value | in
//   rsp     | rsp_valid, rsp_stall, rsp_red/green/blue | out
//   csr     | csr_valid, csr_ready, csr_color_mode | in (write only)
//
// One sample per clock while rsp is not stalled; a result is valid on rsp once it
// has passed the input register, the map register and the result register.
// Reset clears all valid bits and sets the mode to grey; csr_ready is always high.
// A stall on rsp holds the result; stages behind it fill, then req_stall rises.
`default_nettype none

module scalar_colormap (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [scmap_pkg::SAMPLE_W-1:0] req_sample_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [scmap_pkg::CH_W-1:0]                 rsp_red,
   output logic [scmap_pkg::CH_W-1:0]                 rsp_green,
   output logic [scmap_pkg::CH_W-1:0]                 rsp_blue,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [1:0]                            csr_color_mode
);
   import scmap_pkg::*;

   mode_type                    color_mode_ff;

   logic                        in_valid_ff;
   logic signed [SAMPLE_W-1:0]  in_sample_ff;
   mode_type                    in_mode_ff;

   logic                        map_valid_ff;
   map_type                     map_ff;
   map_type                     map_in;
   mode_type                    map_mode_ff;

   logic                        rsp_valid_ff;
   logic [CH_W-1:0]             rsp_red_ff;
   logic [CH_W-1:0]             rsp_green_ff;
   logic [CH_W-1:0]             rsp_blue_ff;
   mode_type                    rsp_mode_ff;
   logic [CH_W-1:0]             rsp_red_in;
   logic [CH_W-1:0]             rsp_green_in;
   logic [CH_W-1:0]             rsp_blue_in;

   logic [CH_W-1:0]             hump_red;
   logic [CH_W-1:0]             hump_green;
   logic [CH_W-1:0]             hump_blue;

   logic                        out_ready;
   logic                        map_ready;
   logic                        in_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= MODE_GREY;
      end else if (csr_valid && csr_ready) begin
         color_mode_ff <= mode_type'(csr_color_mode);
      end
   end

   // a stage advances when it is empty or the one after it advances
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign map_ready = !map_valid_ff || out_ready;
   assign in_ready  = !in_valid_ff || map_ready;
   assign req_stall = !in_ready;

   scmap_warp u_warp (
      .sample (in_sample_ff),
      .mode   (in_mode_ff),
      .map    (map_in)
   );

   scmap_hump u_hump_red (
      .w     (map_ff.w),
      .coef  (RED_COEF),
      .level (hump_red)
   );

   scmap_hump u_hump_green (
      .w     (map_ff.w),
      .coef  (GREEN_COEF),
      .level (hump_green)
   );

   scmap_hump u_hump_blue (
      .w     (map_ff.w),
      .coef  (BLUE_COEF),
      .level (hump_blue)
   );

   always_comb begin
      case (map_mode_ff)
         MODE_GREY: begin
            rsp_red_in   = map_ff.grey;
            rsp_green_in = map_ff.grey;
            rsp_blue_in  = map_ff.grey;
         end
         MODE_RED_WHITE: begin
            rsp_red_in   = CH_MAX;
            rsp_green_in = map_ff.grey;
            rsp_blue_in  = map_ff.grey;
         end
         default: begin
            rsp_red_in   = hump_red;
            rsp_green_in = hump_green;
            rsp_blue_in  = hump_blue;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         map_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_valid;
         end
         if (map_ready) begin
            map_valid_ff <= in_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= map_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         in_sample_ff <= req_sample_value;
         in_mode_ff   <= color_mode_ff;
      end
      if (map_ready && in_valid_ff) begin
         map_ff      <= map_in;
         map_mode_ff <= in_mode_ff;
      end
      if (out_ready && map_valid_ff) begin
         rsp_red_ff   <= rsp_red_in;
         rsp_green_ff <= rsp_green_in;
         rsp_blue_ff  <= rsp_blue_in;
         rsp_mode_ff  <= map_mode_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

   a_grey_equal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_mode_ff == MODE_GREY |->
         rsp_red_ff == rsp_green_ff && rsp_green_ff == rsp_blue_ff)
      else $error("grey result with unequal channels");

   a_red_white_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_mode_ff == MODE_RED_WHITE |->
         rsp_red_ff == CH_MAX && rsp_green_ff == rsp_blue_ff)
      else $error("red to white result malformed");

   a_stall_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && map_valid_ff && rsp_valid_ff)
      else $error("input stalled with room in the pipeline");

   a_drop_after_transfer : assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(!rsp_stall))
      else $error("result dropped without a transfer");

endmodule

`default_nettype wire

// File: hw/rtl/scmap_warp.sv
// First stage of the colormap: clamps the sample and forms the map position.
// Depends on scmap_pkg.
`default_nettype none

module scmap_warp (
   input  wire logic signed [scmap_pkg::SAMPLE_W-1:0] sample,
   input  wire scmap_pkg::mode_type                   mode,
   output scmap_pkg::map_type                         map
);
   import scmap_pkg::*;

   logic              neg;
   logic              over;
   logic [UNIT_W-1:0] unit;
   logic [W_W-1:0]    w_rain;
   logic [17:0]       band_prod;
   logic [5:0]        band_raw;
   logic [2:0]        band;

   always_comb begin
      neg  = sample[SAMPLE_W-1];
      over = !neg && (sample[SAMPLE_W-2:0] > 15'(ONE_Q12));
      if (neg) begin
         unit = '0;
      end else if (over) begin
         unit = ONE_Q12;
      end else begin
         unit = sample[UNIT_W-1:0];
      end

      w_rain = W_W'(unit) * MAP_GAIN + MAP_OFFS;

      // trunc(7v) for positive samples, saturated at the top band
      band_prod = 18'(sample[SAMPLE_W-2:0]) * 18'(NBANDS);
      band_raw  = band_prod[17:12];
      if (neg || sample == '0) begin
         band = '0;
      end else if (band_raw > 6'(NBANDS)) begin
         band = NBANDS;
      end else begin
         band = band_raw[2:0];
      end

      map.w    = (mode == MODE_BANDS) ? band_w(band) : w_rain;
      map.grey = (unit == ONE_Q12) ? CH_MAX : unit[CH_W-1:0];
   end

endmodule

`default_nettype wire

// File: hw/rtl/scmap_hump.sv
// One rainbow channel: max(0, (c - |w-a| - |w-b|) / 2), rounded and saturated.
// Depends on scmap_pkg for the coefficient struct and the divide constants.
`default_nettype none

module scmap_hump (
   input  wire logic [scmap_pkg::W_W-1:0]  w,
   input  wire scmap_pkg::hump_coef_type   coef,
   output logic [scmap_pkg::CH_W-1:0]      level
);
   import scmap_pkg::*;

   localparam int T_W    = W_W + 2;
   localparam int N_W    = 19;
   localparam int PROD_W = 2 * N_W;
   localparam int Q_W    = PROD_W - RECIP_SHIFT;

   logic [W_W-1:0]        dist_a;
   logic [W_W-1:0]        dist_b;
   logic signed [T_W-1:0] t;
   logic [N_W-1:0]        n;
   logic [PROD_W-1:0]     prod;
   logic [Q_W-1:0]        quot;

   always_comb begin
      dist_a = (w >= coef.a_scaled) ? w - coef.a_scaled : coef.a_scaled - w;
      dist_b = (w >= coef.b_scaled) ? w - coef.b_scaled : coef.b_scaled - w;
      t = $signed({2'b00, coef.c_scaled}) - $signed({2'b00, dist_a})
          - $signed({2'b00, dist_b});

      // divide by 70 with round-half-up; positive t stays below 2^19
      n    = t[N_W-1:0] + ROUND_BIAS;
      prod = PROD_W'(n) * PROD_W'(RECIP);
      quot = prod[PROD_W-1:RECIP_SHIFT];

      if (t[T_W-1] || t == '0) begin
         level = '0;
      end else if (quot > Q_W'(CH_MAX)) begin
         level = CH_MAX;
      end else begin
         level = quot[CH_W-1:0];
      end
   end

endmodule

`default_nettype wire
